// ===== rtl/lens_undistort_coordinate_map_defines.svh =====
// ----------------------------------------------------------------------------
// lens undistort coordinate map assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_COORDINATE_MAP_DEFINES_SVH
`define LENS_UNDISTORT_COORDINATE_MAP_DEFINES_SVH

// checked only out of reset
`define LUCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LUCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/lucm_pkg.sv =====
// ----------------------------------------------------------------------------
// lucm_pkg
// widths, register codes, reset values and divider step for the undistort map
// ----------------------------------------------------------------------------
package lucm_pkg;

    localparam int COORD_W     = 10;
    localparam int COEF_W      = 24;
    localparam int INTR_W      = 20;
    localparam int NORM_W      = 24;
    localparam int FRAC_W      = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int TDATA_W     = 24;
    localparam int TAIL_W      = 4;

    localparam int Q_ONE       = 1 << FRAC_W;

    localparam int IMAGE_COLS_DEF = 1024;
    localparam int IMAGE_ROWS_DEF = 1024;

    // normalize divider: one quotient bit per step, two steps per stage
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = NORM_W / DIV_STEPS_PER_STAGE;
    // magnitude, setup, steps, round, saturate
    localparam int DIV_LAT  = DIV_STAGES + 4;
    // divider plus nine arithmetic stages after it
    localparam int PIPE_LAT = DIV_LAT + 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd7;

    localparam logic signed [COEF_W-1:0] K1_RST = -24'sd297175;
    localparam logic signed [COEF_W-1:0] K2_RST = 24'sd77552;
    localparam logic signed [COEF_W-1:0] P1_RST = 24'sd203;
    localparam logic signed [COEF_W-1:0] P2_RST = 24'sd18;
    localparam logic [INTR_W-1:0] FX_RST = 20'd117415;
    localparam logic [INTR_W-1:0] FY_RST = 20'd117068;
    localparam logic [INTR_W-1:0] CX_RST = 20'd94007;
    localparam logic [INTR_W-1:0] CY_RST = 20'd63584;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 24'sh7FFFFF;
    localparam logic signed [NORM_W-1:0] NORM_MIN = 24'sh800000;
    localparam logic [NORM_W:0] NORM_LIM = 25'h0800000;

    typedef struct packed {
        logic [INTR_W-1:0] rem;
        logic [NORM_W-1:0] quo;
        logic [TAIL_W-1:0] tail;
        logic              ovf;
        logic              neg;
    } t_div;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               ok;
    } t_res;

    // one restoring step: bring down a dividend bit, subtract if it fits
    function automatic t_div div_step(t_div d, logic [INTR_W-1:0] f);
        logic [INTR_W:0] t;
        t_div r;
        r = d;
        t = {d.rem, d.tail[TAIL_W-1]};
        r.tail = {d.tail[TAIL_W-2:0], 1'b0};
        if (t >= {1'b0, f}) begin
            r.rem = INTR_W'(t - {1'b0, f});
            r.quo = {d.quo[NORM_W-2:0], 1'b1};
        end else begin
            r.rem = t[INTR_W-1:0];
            r.quo = {d.quo[NORM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/lens_undistort_coordinate_map.sv =====
// ----------------------------------------------------------------------------
// lens_undistort_coordinate_map
// radial and tangential lens model: output pixel to the floored source pixel
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata: out_col, out_row
//  m_axis    out  tvalid / tready           tdata: src_col, src_row; tuser: in_range
//  cfg       in   i_cfg_we (no back-press)  i_cfg_addr, i_cfg_data
//
//  one item per clock while s_axis_tready is high; each item passes through
//  the 24-step normalize divider (two quotient bits a stage)
//  followed by the multiplier chain through r^4, radial gain and pixel scaling
//  i_rst_n is synchronous: clears valid bits and loads the register defaults
//  a two-entry output (register plus skid) lets m_axis stall while s_axis
//  keeps flowing; s_axis_tready drops only once the skid entry is taken
// ----------------------------------------------------------------------------
module lens_undistort_coordinate_map #(
    parameter int IMAGE_COLS = lucm_pkg::IMAGE_COLS_DEF,
    parameter int IMAGE_ROWS = lucm_pkg::IMAGE_ROWS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lucm_pkg::TDATA_W-1:0]         s_axis_tdata,   // out_col, out_row, pad
    // master stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lucm_pkg::TDATA_W-1:0]         m_axis_tdata,   // src_col, src_row, pad
    output logic [0:0]                           m_axis_tuser,   // in_range
    // register writes
    input  logic                                 i_cfg_we,
    input  logic [lucm_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [lucm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW = lucm_pkg::COORD_W;
    localparam int KW = lucm_pkg::COEF_W;
    localparam int IW = lucm_pkg::INTR_W;
    localparam int NW = lucm_pkg::NORM_W;
    localparam int PL = lucm_pkg::PIPE_LAT;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [KW-1:0] r_k1, r_k2, r_p1, r_p2;
    logic [IW-1:0]        r_fx, r_fy, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= lucm_pkg::K1_RST;
            r_k2 <= lucm_pkg::K2_RST;
            r_p1 <= lucm_pkg::P1_RST;
            r_p2 <= lucm_pkg::P2_RST;
            r_fx <= lucm_pkg::FX_RST;
            r_fy <= lucm_pkg::FY_RST;
            r_cx <= lucm_pkg::CX_RST;
            r_cy <= lucm_pkg::CY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lucm_pkg::REG_K1: r_k1 <= $signed(i_cfg_data);
                lucm_pkg::REG_K2: r_k2 <= $signed(i_cfg_data);
                lucm_pkg::REG_P1: r_p1 <= $signed(i_cfg_data);
                lucm_pkg::REG_P2: r_p2 <= $signed(i_cfg_data);
                lucm_pkg::REG_FX: r_fx <= i_cfg_data[IW-1:0];
                lucm_pkg::REG_FY: r_fy <= i_cfg_data[IW-1:0];
                lucm_pkg::REG_CX: r_cx <= i_cfg_data[IW-1:0];
                lucm_pkg::REG_CY: r_cy <= i_cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: everything advances unless the skid entry is full
    // ------------------------------------------------------------------
    logic          w_en;
    logic [PL-1:0] r_vld;
    logic          r_out_vld, r_skid_vld;
    lucm_pkg::t_res r_out, r_skid, n_res;
    logic          w_push;

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;
    assign w_push        = w_en && r_vld[PL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PL-2:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // normalized coordinates x, y (signed Q4.20)
    // ------------------------------------------------------------------
    logic signed [NW-1:0] w_x, w_y;

    lucm_norm_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coord  (s_axis_tdata[CW-1:0]),
        .i_center (r_cx),
        .i_focal  (r_fx),
        .o_norm   (w_x)
    );

    lucm_norm_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coord  (s_axis_tdata[2*CW-1:CW]),
        .i_center (r_cy),
        .i_focal  (r_fy),
        .o_norm   (w_y)
    );

    // ------------------------------------------------------------------
    // squares and cross product
    // ------------------------------------------------------------------
    logic signed [47:0] r_pxx_s16, r_pyy_s16, r_pxy_s16;
    logic signed [NW-1:0] r_x_s16, r_y_s16;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pxx_s16 <= w_x * w_x;
            r_pyy_s16 <= w_y * w_y;
            r_pxy_s16 <= w_x * w_y;
            r_x_s16   <= w_x;
            r_y_s16   <= w_y;
        end
    end

    // r^2 and the tangential weights r^2 + 2x^2, r^2 + 2y^2
    logic signed [29:0] w_xx, w_yy;
    logic signed [28:0] r_r2_s17, r_xy2_s17;
    logic signed [29:0] r_tx_s17, r_ty_s17;
    logic signed [NW-1:0] r_x_s17, r_y_s17;

    assign w_xx = 30'($signed(r_pxx_s16[47:20]));
    assign w_yy = 30'($signed(r_pyy_s16[47:20]));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2_s17  <= 29'(w_xx + w_yy);
            r_tx_s17  <= (w_xx <<< 1) + w_xx + w_yy;
            r_ty_s17  <= (w_yy <<< 1) + w_yy + w_xx;
            // 2*xy with xy already floored
            r_xy2_s17 <= $signed({r_pxy_s16[47:20], 1'b0});
            r_x_s17   <= r_x_s16;
            r_y_s17   <= r_y_s16;
        end
    end

    // ------------------------------------------------------------------
    // coefficient products
    // ------------------------------------------------------------------
    logic [54:0]        r_r4p_s18;
    logic signed [52:0] r_k1r2_s18, r_p1xy_s18, r_p2xy_s18;
    logic signed [53:0] r_p2tx_s18, r_p1ty_s18;
    logic signed [NW-1:0] r_x_s18, r_y_s18;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r4p_s18  <= r_r2_s17[27:0] * r_r2_s17[27:0];
            r_k1r2_s18 <= r_k1 * r_r2_s17;
            r_p1xy_s18 <= r_p1 * r_xy2_s17;
            r_p2xy_s18 <= r_p2 * r_xy2_s17;
            r_p2tx_s18 <= r_p2 * r_tx_s17;
            r_p1ty_s18 <= r_p1 * r_ty_s17;
            r_x_s18    <= r_x_s17;
            r_y_s18    <= r_y_s17;
        end
    end

    // k2*r^4 split at bit 20 of r^4 so each product stays narrow;
    // the high half times k2 is already a whole Q.20 count
    logic signed [39:0] r_k2h_s19;
    logic signed [44:0] r_k2l_s19;
    logic signed [33:0] r_a_s19;
    logic signed [34:0] r_tgx_s19, r_tgy_s19;
    logic signed [NW-1:0] r_x_s19, r_y_s19;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k2h_s19 <= r_k2 * $signed({1'b0, r_r4p_s18[54:40]});
            r_k2l_s19 <= r_k2 * $signed({1'b0, r_r4p_s18[39:20]});
            r_a_s19   <= 34'($signed(r_k1r2_s18[52:20])) + 34'(lucm_pkg::Q_ONE);
            r_tgx_s19 <= 35'($signed(r_p1xy_s18[52:20])) + 35'($signed(r_p2tx_s18[53:20]));
            r_tgy_s19 <= 35'($signed(r_p1ty_s18[53:20])) + 35'($signed(r_p2xy_s18[52:20]));
            r_x_s19   <= r_x_s18;
            r_y_s19   <= r_y_s18;
        end
    end

    // radial gain 1 + k1*r^2 + k2*r^4
    logic signed [39:0] r_rad_s20;
    logic signed [34:0] r_tgx_s20, r_tgy_s20;
    logic signed [NW-1:0] r_x_s20, r_y_s20;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad_s20 <= r_k2h_s19 + 40'(r_a_s19) + 40'($signed(r_k2l_s19[44:20]));
            r_tgx_s20 <= r_tgx_s19;
            r_tgy_s20 <= r_tgy_s19;
            r_x_s20   <= r_x_s19;
            r_y_s20   <= r_y_s19;
        end
    end

    // x*rad split the same way: integer part of rad, then its fraction
    logic signed [43:0] r_xrh_s21, r_yrh_s21;
    logic signed [44:0] r_xrl_s21, r_yrl_s21;
    logic signed [34:0] r_tgx_s21, r_tgy_s21;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xrh_s21 <= r_x_s20 * $signed(r_rad_s20[39:20]);
            r_xrl_s21 <= r_x_s20 * $signed({1'b0, r_rad_s20[19:0]});
            r_yrh_s21 <= r_y_s20 * $signed(r_rad_s20[39:20]);
            r_yrl_s21 <= r_y_s20 * $signed({1'b0, r_rad_s20[19:0]});
            r_tgx_s21 <= r_tgx_s20;
            r_tgy_s21 <= r_tgy_s20;
        end
    end

    // distorted normalized point
    logic signed [45:0] r_xd_s22, r_yd_s22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd_s22 <= 46'(r_xrh_s21) + 46'($signed(r_xrl_s21[44:20])) + 46'(r_tgx_s21);
            r_yd_s22 <= 46'(r_yrh_s21) + 46'($signed(r_yrl_s21[44:20])) + 46'(r_tgy_s21);
        end
    end

    // back to pixels: focal * xd, again split at bit 20 of xd
    logic signed [46:0] r_uph_s23, r_vph_s23;
    logic [39:0]        r_upl_s23, r_vpl_s23;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_uph_s23 <= $signed({1'b0, r_fx}) * $signed(r_xd_s22[45:20]);
            r_upl_s23 <= r_fx * r_xd_s22[19:0];
            r_vph_s23 <= $signed({1'b0, r_fy}) * $signed(r_yd_s22[45:20]);
            r_vpl_s23 <= r_fy * r_yd_s22[19:0];
        end
    end

    // source position in Q.8 pixels (floor of the Q.28 value by 2^20)
    logic signed [47:0] r_u_s24, r_v_s24;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_s24 <= 48'(r_uph_s23) + 48'($signed({1'b0, r_cx}))
                     + 48'($signed({1'b0, r_upl_s23[39:20]}));
            r_v_s24 <= 48'(r_vph_s23) + 48'($signed({1'b0, r_cy}))
                     + 48'($signed({1'b0, r_vpl_s23[39:20]}));
        end
    end

    // ------------------------------------------------------------------
    // range check and floor
    // ------------------------------------------------------------------
    logic w_ok_u, w_ok_v;

    assign w_ok_u = !r_u_s24[47] && (r_u_s24[46:8] < 39'(IMAGE_COLS));
    assign w_ok_v = !r_v_s24[47] && (r_v_s24[46:8] < 39'(IMAGE_ROWS));

    always_comb begin
        n_res.ok  = w_ok_u && w_ok_v;
        n_res.col = n_res.ok ? r_u_s24[CW+7:8] : '0;
        n_res.row = n_res.ok ? r_v_s24[CW+7:8] : '0;
    end

    // ------------------------------------------------------------------
    // output register and skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= w_push;
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out <= n_res;
        end else if (w_push) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(lucm_pkg::TDATA_W - 2*CW)'(0), r_out.row, r_out.col};
    assign m_axis_tuser  = r_out.ok;

endmodule

// ===== rtl/lucm_norm_div.sv =====
// ----------------------------------------------------------------------------
// lucm_norm_div
// pipelined normalize: ((coord<<8) - center) * 2^20 / focal, saturated Q4.20
// ----------------------------------------------------------------------------
module lucm_norm_div (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [lucm_pkg::COORD_W-1:0]           i_coord,
    input  logic [lucm_pkg::INTR_W-1:0]            i_center,
    input  logic [lucm_pkg::INTR_W-1:0]            i_focal,
    output logic signed [lucm_pkg::NORM_W-1:0]    o_norm
);

    localparam int IW = lucm_pkg::INTR_W;
    localparam int NW = lucm_pkg::NORM_W;
    localparam int TW = lucm_pkg::TAIL_W;

    logic [IW-1:0] n_pos;
    logic [IW-1:0] w_f;
    logic [IW-1:0] r_mag;
    logic          r_neg;
    lucm_pkg::t_div r_div [0:lucm_pkg::DIV_STAGES];
    logic [NW:0]   r_mag2;
    logic          r_ovf2;
    logic          r_neg2;
    logic signed [NW-1:0] r_norm;

    assign n_pos = IW'({i_coord, 8'b0});
    // zero focal length counts as one lsb
    assign w_f   = (i_focal == '0) ? IW'(1) : i_focal;

    // magnitude and sign of the centered coordinate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= n_pos < i_center;
            r_mag <= (n_pos < i_center) ? (i_center - n_pos) : (n_pos - i_center);
        end
    end

    // quotient above 24 bits is flagged here and saturated at the end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0].rem  <= {4'b0, r_mag[IW-1:TW]};
            r_div[0].tail <= r_mag[TW-1:0];
            r_div[0].quo  <= '0;
            r_div[0].ovf  <= {4'b0, r_mag} >= {w_f, 4'b0};
            r_div[0].neg  <= r_neg;
        end
    end

    for (genvar g = 1; g <= lucm_pkg::DIV_STAGES; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[g] <= lucm_pkg::div_step(lucm_pkg::div_step(r_div[g-1], w_f), w_f);
            end
        end
    end

    // negative results round away from zero (ceiling of the magnitude)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag2 <= {1'b0, r_div[lucm_pkg::DIV_STAGES].quo}
                    + (NW+1)'(r_div[lucm_pkg::DIV_STAGES].neg
                               && (r_div[lucm_pkg::DIV_STAGES].rem != '0));
            r_ovf2 <= r_div[lucm_pkg::DIV_STAGES].ovf;
            r_neg2 <= r_div[lucm_pkg::DIV_STAGES].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf2 || (r_mag2 >= lucm_pkg::NORM_LIM)) begin
                r_norm <= r_neg2 ? lucm_pkg::NORM_MIN : lucm_pkg::NORM_MAX;
            end else begin
                r_norm <= r_neg2 ? $signed(NW'((NW+1)'(0) - r_mag2))
                                 : $signed(r_mag2[NW-1:0]);
            end
        end
    end

    assign o_norm = r_norm;

endmodule

// ===== rtl/lucm_check.sv =====
// ----------------------------------------------------------------------------
// lucm_check
// port-level checks for the undistort map, bound to the top level
// ----------------------------------------------------------------------------
`include "lens_undistort_coordinate_map_defines.svh"

module lucm_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lucm_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                   m_axis_tuser
);

    // a stalled result stays offered
    `LUCM_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // an out-of-range result carries zero coordinates
    `LUCM_ASSERT(a_black_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "out-of-range result with nonzero coordinates")

    // input is held off only behind a result that was stalled
    `LUCM_ASSERT(a_ready_cause, !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready), "input held off without an output stall")

    // reset empties the output and opens the input
    `LUCM_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "output or skid not cleared by reset")

endmodule

bind lens_undistort_coordinate_map lucm_check u_lucm_check (.*);
